/* hdl/arx_pkg.sv */
package arx_pkg;

	// Build-time defaults for the top level.
	localparam int FEEDBACK_ORDER_DEF    = 3;
	localparam int FEEDFORWARD_ORDER_DEF = 3;
	localparam int MAX_DELAY_DEF         = 16;
	localparam int SAMPLE_WIDTH_DEF      = 16;

	// Fixed formats of the register file.
	localparam int COEF_W     = 16;
	localparam int COEF_FRAC  = 14;
	localparam int DELAY_W    = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_COEF_1,
		CFG_A_COEF_2,
		CFG_A_COEF_3,
		CFG_B_COEF_0,
		CFG_B_COEF_1,
		CFG_B_COEF_2,
		CFG_DELAY_SAMPLES,
		CFG_NOISE_ENABLE
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} arx_state_t;

endpackage

/* hdl/arx_model_step.sv */
// Channel   Dir   Payload (lowest bit first)                         Handshake
// s_*       in    tdata: input_sample, noise_sample                  tvalid / tready
// m_*       out   tdata: output_sample; tuser: saturated             tvalid / tready
// cfg_*     in    cfg_index: register index; cfg_data: value         cfg_valid / cfg_ready
//
// After acceptance, at which the delay line is read, an item passes through the
// write and history update step, a multiply-accumulate step for each tap on the
// shared multiplier (FEEDBACK_ORDER + FEEDFORWARD_ORDER), a drain step and a
// finish step that loads its result into the output register. The next item is
// taken only once the sequencer is back in idle after the finish step, so items
// do not overlap; the single multiplier serves every tap.
// The next item is accepted while a finished result still waits in the output
// register; the finish step holds only if that register is still full.
// Reset clears the histories, delay line valid bits, pointer, configuration and
// control registers, not the datapath ones; configuration writes are always taken.
module arx_model_step
	import arx_pkg::*;
#(
	parameter int FEEDBACK_ORDER    = FEEDBACK_ORDER_DEF,
	parameter int FEEDFORWARD_ORDER = FEEDFORWARD_ORDER_DEF,
	parameter int MAX_DELAY         = MAX_DELAY_DEF,
	parameter int SAMPLE_WIDTH      = SAMPLE_WIDTH_DEF,
	localparam int SIN_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int SOUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SIN_W-1:0]      s_tdata,   // input_sample, noise_sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [SOUT_W-1:0]     m_tdata,   // output_sample
	output logic                  m_tuser,   // saturated
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int FB   = FEEDBACK_ORDER;
	localparam int FF   = FEEDFORWARD_ORDER;
	localparam int NT   = FB + FF;
	localparam int TW   = (NT > 1) ? $clog2(NT) : 1;
	localparam int PW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int CW   = $clog2(2 * MAX_DELAY + 32);
	localparam int PRW  = SW + COEF_W;
	localparam int ACCW = PRW + 3;
	localparam int RW   = ACCW - COEF_FRAC;
	localparam int YW   = RW + 1;

	localparam logic signed [YW-1:0] Y_MAX = {{(YW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
	localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;
	localparam logic signed [ACCW-1:0] RND_HALF = ACCW'(1) <<< (COEF_FRAC - 1);

	// Configuration registers.
	logic signed [COEF_W-1:0] a_coef_q [3];
	logic signed [COEF_W-1:0] b_coef_q [3];
	logic [DELAY_W-1:0]       delay_q;
	logic                     noise_en_q;

	// Sequencer.
	arx_state_t state_q, state_nxt;
	logic       mem_re, mem_we, in_push, mac_en, done_fire, out_free;
	logic [TW-1:0] tap_q;
	logic          tap_last;

	// Delay line memory and its valid bits.
	logic [SW-1:0]        dly_mem [MAX_DELAY];
	logic [MAX_DELAY-1:0] dly_vld_q;
	logic [PW-1:0]        ptr_q;
	logic [PW-1:0]        rd_addr;
	logic [SW-1:0]        rd_data_s1;
	logic                 rd_vld_s1;
	logic [CW-1:0]        d_ext, d_sat, addr_sum, addr_mod;

	// Item payload and histories.
	logic signed [SW-1:0] u_q, noise_q, ud;
	logic signed [SW-1:0] y_hist_q [FB];
	logic signed [SW-1:0] u_hist_q [FF];

	// Datapath.
	logic signed [SW-1:0]     smp_sel;
	logic signed [COEF_W-1:0] coef_sel;
	logic signed [PRW-1:0]    prod;
	logic signed [PRW-1:0]    mul_s1;
	logic                     sub_s1, mul_vld_s1;
	logic signed [ACCW-1:0]   acc_q, acc_rnd;
	logic signed [RW-1:0]     y_rnd;
	logic signed [YW-1:0]     y_pre;
	logic signed [SW-1:0]     y_sat;
	logic                     sat_flag;
	logic [SW-1:0]            out_sample_q;
	logic                     out_sat_q, out_valid_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = SOUT_W'(out_sample_q);
	assign m_tuser   = out_sat_q;
	assign out_free  = !out_valid_q || m_tready;
	assign tap_last  = (tap_q == TW'(NT - 1));

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				a_coef_q[j] <= '0;
				b_coef_q[j] <= '0;
			end
			delay_q    <= '0;
			noise_en_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_A_COEF_1:      a_coef_q[0] <= cfg_data;
				CFG_A_COEF_2:      a_coef_q[1] <= cfg_data;
				CFG_A_COEF_3:      a_coef_q[2] <= cfg_data;
				CFG_B_COEF_0:      b_coef_q[0] <= cfg_data;
				CFG_B_COEF_1:      b_coef_q[1] <= cfg_data;
				CFG_B_COEF_2:      b_coef_q[2] <= cfg_data;
				CFG_DELAY_SAMPLES: delay_q     <= cfg_data[DELAY_W-1:0];
				CFG_NOISE_ENABLE:  noise_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_nxt = ST_READ;
			ST_READ:  state_nxt = ST_MAC;
			ST_MAC:   if (tap_last) state_nxt = ST_DRAIN;
			ST_DRAIN: state_nxt = ST_DONE;
			ST_DONE:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		in_push   = 1'b0;
		mac_en    = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:  mem_re = s_tvalid;
			ST_READ: begin
				mem_we  = 1'b1;
				in_push = 1'b1;
			end
			ST_MAC:   mac_en = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  done_fire = out_free;
			default: ;
		endcase
	end

	// Read address: the entry written d items ago, with the delay clipped.
	always_comb begin
		d_ext    = CW'(delay_q);
		d_sat    = (d_ext > CW'(MAX_DELAY)) ? CW'(MAX_DELAY) : d_ext;
		addr_sum = CW'(ptr_q) + CW'(MAX_DELAY) - d_sat;
		addr_mod = (addr_sum >= CW'(MAX_DELAY)) ? addr_sum - CW'(MAX_DELAY) : addr_sum;
		rd_addr  = addr_mod[PW-1:0];
	end

	// The read happens on acceptance and the write in the next cycle, so a delay
	// of MAX_DELAY still sees the old entry at the pointer.
	always_ff @(posedge clk) begin
		if (mem_we) dly_mem[ptr_q] <= u_q;
		if (mem_re) begin
			rd_data_s1 <= dly_mem[rd_addr];
			rd_vld_s1  <= dly_vld_q[rd_addr];
		end
	end

	assign ud = (delay_q == '0) ? u_q : (rd_vld_s1 ? $signed(rd_data_s1) : '0);

	// Tap selection for the shared multiplier.
	always_comb begin
		smp_sel  = '0;
		coef_sel = '0;
		for (int j = 0; j < FB; j++) begin
			if (tap_q == TW'(j)) begin
				smp_sel  = y_hist_q[j];
				coef_sel = a_coef_q[j];
			end
		end
		for (int j = 0; j < FF; j++) begin
			if (tap_q == TW'(FB + j)) begin
				smp_sel  = u_hist_q[j];
				coef_sel = b_coef_q[j];
			end
		end
	end

	assign prod = smp_sel * coef_sel;

	// Round half up to Q1.15, add noise, clip.
	always_comb begin
		acc_rnd  = acc_q + RND_HALF;
		y_rnd    = acc_rnd[ACCW-1:COEF_FRAC];
		y_pre    = YW'(y_rnd) + (noise_en_q ? YW'(noise_q) : YW'(0));
		sat_flag = 1'b0;
		if (y_pre > Y_MAX) begin
			y_sat    = Y_MAX[SW-1:0];
			sat_flag = 1'b1;
		end else if (y_pre < Y_MIN) begin
			y_sat    = Y_MIN[SW-1:0];
			sat_flag = 1'b1;
		end else begin
			y_sat = y_pre[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			dly_vld_q   <= '0;
			tap_q       <= '0;
			mul_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < FB; j++) y_hist_q[j] <= '0;
			for (int j = 0; j < FF; j++) u_hist_q[j] <= '0;
		end else begin
			state_q    <= state_nxt;
			mul_vld_s1 <= mac_en;
			if (mem_we) begin
				dly_vld_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == PW'(MAX_DELAY - 1)) ? '0 : ptr_q + PW'(1);
			end
			if (in_push) begin
				for (int j = FF - 1; j > 0; j--) u_hist_q[j] <= u_hist_q[j-1];
				u_hist_q[0] <= ud;
				tap_q <= '0;
			end
			if (mac_en) tap_q <= tap_q + TW'(1);
			if (done_fire) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			if (done_fire) begin
				for (int j = FB - 1; j > 0; j--) y_hist_q[j] <= y_hist_q[j-1];
				y_hist_q[0] <= y_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			u_q     <= s_tdata[SW-1:0];
			noise_q <= s_tdata[2*SW-1:SW];
		end
		if (in_push) acc_q <= '0;
		else if (mul_vld_s1) acc_q <= sub_s1 ? acc_q - ACCW'(mul_s1) : acc_q + ACCW'(mul_s1);
		if (mac_en) begin
			mul_s1 <= prod;
			sub_s1 <= (tap_q < TW'(FB));
		end
		if (done_fire) begin
			out_sample_q <= y_sat;
			out_sat_q    <= sat_flag;
		end
	end

endmodule

/* hdl/arx_model_step_chk.sv */
module arx_model_step_chk
	import arx_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int SOUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [SOUT_W-1:0] m_tdata,
	input logic              m_tuser
);

	localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

	// A result waiting at the output holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after an item");

	// An idle block stays ready until an item arrives.
	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("ready dropped without an item");

	// A clipped result sits exactly at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			(m_tdata[SAMPLE_WIDTH-1:0] == S_MAX) || (m_tdata[SAMPLE_WIDTH-1:0] == S_MIN))
		else $error("saturation flag without a limit value");

	// A new result appears only at the end of an item's work.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

endmodule

bind arx_model_step arx_model_step_chk #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_arx_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* sim/arx_model_step_tb.sv */
`timescale 1ns / 100ps

module arx_model_step_tb;
	import arx_pkg::*;

	localparam int  SW           = SAMPLE_WIDTH_DEF;
	localparam int  NUM_DIRECTED = 30;
	localparam int  NUM_PHASES   = 10;
	localparam int  PHASE_ITEMS  = 43;
	localparam int  CYCLE_LIMIT  = 200000;
	localparam longint Y_MAX     = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint Y_MIN     = -Y_MAX - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = '1;

	typedef struct packed {
		logic signed [SW-1:0] y;
		logic                 sat;
	} arx_out_t;

	typedef struct {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] val;
		logic [SW-1:0]        u;
		logic [SW-1:0]        n;
		logic                 chk;
		logic [SW-1:0]        y;
		logic                 sat;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [2*SW-1:0]       s_tdata;   // input_sample, noise_sample
	logic                  m_tvalid;
	logic                  m_tready;
	logic [SW-1:0]         m_tdata;   // output_sample
	logic                  m_tuser;   // saturated
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the registers and the plant state.
	logic signed [SW-1:0] a_coef [3] = '{default: '0};
	logic signed [SW-1:0] b_coef [3] = '{default: '0};
	logic [DELAY_W-1:0]   delay_cfg = '0;
	logic                 noise_on = 1'b0;
	logic signed [SW-1:0] delay_line [MAX_DELAY_DEF] = '{default: '0};
	logic [3:0]           delay_ptr = '0;
	logic signed [SW-1:0] u_hist [3] = '{default: '0};
	logic signed [SW-1:0] y_hist [3] = '{default: '0};

	arx_out_t  pending_outputs[$];
	arx_out_t  oldest_output;
	stim_row_t directed_rows [NUM_DIRECTED];
	int        error_count = 0;
	int        cycle_count = 0;
	int        burst_left = 0;
	logic      gaps_on = 1'b1;
	int        ready_stall_pct = 0;
	int        stall_left = 0;

	arx_model_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_A_COEF_1:      a_coef[0] = val;
			CFG_A_COEF_2:      a_coef[1] = val;
			CFG_A_COEF_3:      a_coef[2] = val;
			CFG_B_COEF_0:      b_coef[0] = val;
			CFG_B_COEF_1:      b_coef[1] = val;
			CFG_B_COEF_2:      b_coef[2] = val;
			CFG_DELAY_SAMPLES: delay_cfg = val[DELAY_W-1:0];
			CFG_NOISE_ENABLE:  noise_on = val[0];
			default: ;
		endcase
	endfunction

	// Advances the plant by one sample and returns the saturated output.
	function automatic arx_out_t arx_predict(input logic signed [SW-1:0] u,
		input logic signed [SW-1:0] n);
		logic [DELAY_W-1:0]   d;
		logic signed [SW-1:0] ud;
		longint               acc;
		longint               y;
		arx_out_t             r;
		d = (delay_cfg > MAX_DELAY_DEF) ? DELAY_W'(MAX_DELAY_DEF) : delay_cfg;
		// A delay of the full line length reads the entry about to be overwritten.
		if (d == 0)
			ud = u;
		else
			ud = delay_line[4'(delay_ptr - d)];
		delay_line[delay_ptr] = u;
		delay_ptr = delay_ptr + 1'b1;
		u_hist[2] = u_hist[1];
		u_hist[1] = u_hist[0];
		u_hist[0] = ud;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			acc -= longint'(a_coef[i]) * longint'(y_hist[i]);
			acc += longint'(b_coef[i]) * longint'(u_hist[i]);
		end
		y = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		if (noise_on)
			y += longint'(n);
		r.sat = 1'b0;
		if (y > Y_MAX) begin
			y = Y_MAX;
			r.sat = 1'b1;
		end else if (y < Y_MIN) begin
			y = Y_MIN;
			r.sat = 1'b1;
		end
		r.y = SW'(y);
		y_hist[2] = y_hist[1];
		y_hist[1] = y_hist[0];
		y_hist[0] = r.y;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '{is_cfg: 1'b1, idx: idx, val: val, default: '0};
		return r;
	endfunction

	function automatic stim_row_t item_row(input logic [SW-1:0] u, input logic [SW-1:0] n);
		stim_row_t r;
		r = '{u: u, n: n, default: '0};
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [SW-1:0] u, input logic [SW-1:0] n,
		input logic [SW-1:0] y, input logic sat);
		stim_row_t r;
		r = '{u: u, n: n, chk: 1'b1, y: y, sat: sat, default: '0};
		return r;
	endfunction

	function automatic logic [SW-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
			1: return SW'(int'($urandom_range(0, 512)) - 256);
			default: return SW'($urandom);
		endcase
	endfunction

	// Mode 0 and 1 are the two extremes, 2 mixes extremes, 3 keeps the loop
	// stable so that outputs mostly stay in range, 4 is fully random.
	function automatic logic [COEF_W-1:0] rand_coef(input int mode, input logic feedback);
		case (mode)
			0: return 16'h7fff;
			1: return 16'h8000;
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h7fff;
					1: return 16'h8000;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
			3: return feedback ? COEF_W'(int'($urandom_range(0, 4096)) - 2048)
				: COEF_W'(int'($urandom_range(0, 16384)) - 8192);
			default: return COEF_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [SW-1:0] u, input logic [SW-1:0] n,
		input logic chk, input logic [SW-1:0] y, input logic sat);
		arx_out_t predicted;
		s_tdata <= {n, u};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = arx_predict(u, n);
		if (chk) begin
			predicted.y = y;
			predicted.sat = sat;
		end
		pending_outputs.insert(pending_outputs.size(), predicted);
		if (gaps_on && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end else if (burst_left != 0) begin
			burst_left--;
		end
	endtask

	// Leaves cfg_valid high so that back-to-back writes never drop it.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_cfg(idx, val);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < ready_stall_pct) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 14);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected item, expected none, got output_sample %0d saturated %0b",
					$time, $signed(m_tdata), m_tuser);
				error_count++;
			end else begin
				oldest_output = pending_outputs[0];
				pending_outputs.delete(0);
				if (m_tdata !== oldest_output.y) begin
					$display("%0t: output_sample mismatch, expected %0d, got %0d",
						$time, oldest_output.y, $signed(m_tdata));
					error_count++;
				end
				if (m_tuser !== oldest_output.sat) begin
					$display("%0t: saturated mismatch, expected %0b, got %0b",
						$time, oldest_output.sat, m_tuser);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int mode;
		int stall_modes [4];
		stall_modes = '{0, 10, 30, 60};
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		directed_rows = '{
			typed_row(16'h7fff, 16'h8000, 16'h0000, 1'b0),
			typed_row(16'h8000, 16'h7fff, 16'h0000, 1'b0),
			cfg_row(CFG_NOISE_ENABLE, 16'h0001),
			typed_row(16'h0000, 16'h7fff, 16'h7fff, 1'b0),
			typed_row(16'h0000, 16'h8000, 16'h8000, 1'b0),
			cfg_row(CFG_B_COEF_0, 16'h7fff),
			typed_row(16'h7fff, 16'h0000, 16'h7fff, 1'b1),
			typed_row(16'h8000, 16'h0000, 16'h8000, 1'b1),
			// Noise alone lands exactly on the bottom of the range: no clipping.
			typed_row(16'h0000, 16'h8000, 16'h8000, 1'b0),
			cfg_row(CFG_NOISE_ENABLE, 16'h0000),
			cfg_row(CFG_A_COEF_1, 16'h8000),
			cfg_row(CFG_A_COEF_2, 16'h7fff),
			cfg_row(CFG_A_COEF_3, 16'h4000),
			cfg_row(CFG_B_COEF_1, 16'h8000),
			cfg_row(CFG_B_COEF_2, 16'h2000),
			cfg_row(CFG_B_COEF_0, 16'h0400),
			item_row(16'h1234, 16'h7fff),
			item_row(16'h8000, 16'h0001),
			item_row(16'h7fff, 16'hffff),
			cfg_row(CFG_DELAY_SAMPLES, 16'd16),
			item_row(16'h0100, 16'h0000),
			item_row(16'hfe00, 16'h0000),
			item_row(16'h7fff, 16'h0000),
			// Above the line length: behaves as the longest delay.
			cfg_row(CFG_DELAY_SAMPLES, 16'd31),
			item_row(16'h0001, 16'h0000),
			item_row(16'h8000, 16'h0000),
			cfg_row(CFG_DELAY_SAMPLES, 16'd1),
			cfg_row(CFG_SPARE_IDX, 16'hffff),
			item_row(16'h4000, 16'h0000),
			item_row(16'hc000, 16'h0000)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = $urandom_range(1, 12);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				cfg_write(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				cfg_valid <= 1'b0;
				send_item(directed_rows[i].u, directed_rows[i].n, directed_rows[i].chk,
					directed_rows[i].y, directed_rows[i].sat);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			if (p < 2)
				mode = p;
			else
				mode = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 3;
			cfg_write(CFG_A_COEF_1, rand_coef(mode, 1'b1));
			cfg_write(CFG_A_COEF_2, rand_coef(mode, 1'b1));
			cfg_write(CFG_A_COEF_3, rand_coef(mode, 1'b1));
			cfg_write(CFG_B_COEF_0, rand_coef(mode, 1'b0));
			cfg_write(CFG_B_COEF_1, rand_coef(mode, 1'b0));
			cfg_write(CFG_B_COEF_2, rand_coef(mode, 1'b0));
			if (p == 0)
				cfg_write(CFG_DELAY_SAMPLES, CFG_DATA_W'(MAX_DELAY_DEF));
			else if (p == 1)
				cfg_write(CFG_DELAY_SAMPLES, '0);
			else if ($urandom_range(0, 4) == 0)
				cfg_write(CFG_DELAY_SAMPLES, CFG_DATA_W'($urandom_range(17, 31)));
			else
				cfg_write(CFG_DELAY_SAMPLES, CFG_DATA_W'($urandom_range(0, 16)));
			cfg_write(CFG_NOISE_ENABLE, (p == 0) ? 16'h0001 : (p == 1) ? 16'h0000
				: CFG_DATA_W'($urandom));
			if ($urandom_range(0, 3) == 0)
				cfg_write(CFG_IDX_W'($urandom_range(int'(CFG_NOISE_ENABLE) + 1,
					(1 << CFG_IDX_W) - 1)), CFG_DATA_W'($urandom));
			cfg_valid <= 1'b0;
			gaps_on = ($urandom_range(0, 3) != 0);
			ready_stall_pct = stall_modes[$urandom_range(0, 3)];
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_item(rand_sample(), rand_sample(), 1'b0, '0, 1'b0);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
